// File: sv/rsiw_pkg.sv
// ----------------------------------------------------------------------------
// RSI Wilder smoothing package
// Shared widths, constants, state codes and controller/datapath bundles.
// ----------------------------------------------------------------------------
package rsiw_pkg;

    localparam int CLOSE_W     = 32;
    localparam int PRICE_W     = 32;
    localparam int AVG_W       = PRICE_W + 16;
    localparam int WIN_W       = 8;
    localparam int RSI_W       = 23;
    localparam int ADDR_W      = 2;
    localparam int DATA_W      = 32;
    localparam int PROD_W      = AVG_W + 7;
    localparam int SUM_W       = AVG_W + 1;
    localparam int DIV_STEPS   = AVG_W;
    localparam int RATIO_STEPS = RSI_W;
    localparam int CNT_W       = $clog2(DIV_STEPS);

    localparam logic [ADDR_W-1:0] REG_WINDOW_LENGTH = 2'd0;
    localparam logic [WIN_W-1:0]  WINDOW_RESET      = 8'd14;
    localparam logic [RSI_W-1:0]  RSI_FULL          = 23'd6553600;
    localparam logic [RSI_W-1:0]  RSI_HALF          = 23'd3276800;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DIV   = 6'b000010,
        S_UPD   = 6'b000100,
        S_MUL   = 6'b001000,
        S_RATIO = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    typedef struct packed {
        logic load;
        logic first;
        logic div_step;
        logic upd;
        logic mul;
        logic ratio_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic loss_zero;
    } t_sts;

endpackage

// File: sv/rsiw_stream_if.sv
// ----------------------------------------------------------------------------
// RSI Wilder smoothing stream interfaces
// Price input channel and RSI result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rsiw_in_if;
    logic                         valid;
    logic                         ready;
    logic [rsiw_pkg::CLOSE_W-1:0] close_price;
    logic                         first_of_series;
    logic                         warmup;
    logic                         end_of_series;

    modport source (
        output valid, close_price, first_of_series, warmup, end_of_series,
        input  ready
    );
    modport sink (
        input  valid, close_price, first_of_series, warmup, end_of_series,
        output ready
    );
endinterface

interface rsiw_out_if;
    logic                       valid;
    logic                       ready;
    logic [rsiw_pkg::RSI_W-1:0] rsi_value;
    logic                       series_last;

    modport source (
        output valid, rsi_value, series_last,
        input  ready
    );
    modport sink (
        input  valid, rsi_value, series_last,
        output ready
    );
endinterface

// File: sv/rsi_wilder_smoothing_top.sv
// ----------------------------------------------------------------------------
// RSI Wilder smoothing top level
// Relative strength index over a stream of Q16.16 closing prices.
// ----------------------------------------------------------------------------
// Closing prices enter on i_price, one word per handshake, with flags for
// the start of a series, warm-up and the end of a series. Results leave on
// o_rsi as Q7.16 words with a copy of the end-of-series flag.
// The smoothing period is written through the APB port at byte address 0.
// A word that starts a series clears the averages, stores its close and gives
// no result. Any other word is loaded, divided bit-serially by the period
// (gain and loss lanes side by side) and then updates the averages; a warm-up
// word ends there. A word with a result then forms the scaled numerator and
// runs the serial ratio divider, skipped when the average loss is zero, then
// moves into the output register. Each word is finished before the next is taken.
// After reset the averages and previous close are zero and the period is 14.
// A result waits in the output register while the receiver stalls; the next
// word is still accepted and worked on, and only its own result waits.
// ----------------------------------------------------------------------------
module rsi_wilder_smoothing_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rsiw_pkg::ADDR_W-1:0]   paddr,
    input  logic [rsiw_pkg::DATA_W-1:0]   pwdata,
    output logic [rsiw_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    rsiw_in_if.sink                       i_price,
    rsiw_out_if.source                    o_rsi
);

    rsiw_pkg::t_cmd             cmd;
    rsiw_pkg::t_sts             sts;
    logic [rsiw_pkg::WIN_W-1:0] divisor;

    rsiw_apb_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_divisor (divisor)
    );

    rsiw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_price.valid),
        .i_first     (i_price.first_of_series),
        .i_warmup    (i_price.warmup),
        .i_out_ready (o_rsi.ready),
        .i_sts       (sts),
        .o_in_ready  (i_price.ready),
        .o_out_valid (o_rsi.valid),
        .o_cmd       (cmd)
    );

    rsiw_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_divisor       (divisor),
        .i_close_price   (i_price.close_price),
        .i_end_of_series (i_price.end_of_series),
        .o_sts           (sts),
        .o_rsi_value     (o_rsi.rsi_value),
        .o_series_last   (o_rsi.series_last)
    );

    // The index never exceeds full scale.
    a_rsi_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsi.valid |-> (o_rsi.rsi_value <= rsiw_pkg::RSI_FULL))
        else $error("RSI value above full scale");

    // A word that continues a series keeps the block busy for the next cycle.
    a_busy_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_price.valid && i_price.ready && !i_price.first_of_series) |=> !i_price.ready)
        else $error("input ready while a word is being processed");

    // A word that starts a series leaves the block free for the next word.
    a_first_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_price.valid && i_price.ready && i_price.first_of_series) |=> i_price.ready)
        else $error("series start word did not return to idle");

    // A new result appears only at the end of processing a word.
    a_result_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsi.valid) |-> $past(!i_price.ready))
        else $error("result appeared without a word in progress");

endmodule

// File: sv/rsiw_apb_regs.sv
// ----------------------------------------------------------------------------
// RSI Wilder smoothing register file
// Holds the window length and supplies the effective divisor.
// ----------------------------------------------------------------------------
module rsiw_apb_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [rsiw_pkg::ADDR_W-1:0]   i_paddr,
    input  logic [rsiw_pkg::DATA_W-1:0]   i_pwdata,
    output logic [rsiw_pkg::DATA_W-1:0]   o_prdata,
    output logic                          o_pready,
    output logic [rsiw_pkg::WIN_W-1:0]    o_divisor
);

    logic [rsiw_pkg::WIN_W-1:0] r_window;
    logic [rsiw_pkg::WIN_W-1:0] n_window;
    logic                       wr_en;

    assign wr_en = i_psel & i_penable & i_pwrite & o_pready
                   & (i_paddr == rsiw_pkg::REG_WINDOW_LENGTH);

    always_comb begin
        n_window = r_window;
        if (wr_en) begin
            n_window = i_pwdata[rsiw_pkg::WIN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= rsiw_pkg::WINDOW_RESET;
        end else begin
            r_window <= n_window;
        end
    end

    // A window length of zero behaves as one.
    assign o_divisor = (r_window == '0) ? rsiw_pkg::WIN_W'(1) : r_window;
    assign o_pready  = 1'b1;
    assign o_prdata  = (i_paddr == rsiw_pkg::REG_WINDOW_LENGTH)
                       ? {{(rsiw_pkg::DATA_W-rsiw_pkg::WIN_W){1'b0}}, r_window}
                       : '0;

endmodule

// File: sv/rsiw_ctrl.sv
// ----------------------------------------------------------------------------
// RSI Wilder smoothing controller
// Sequences load, serial division, average update, ratio and output.
// ----------------------------------------------------------------------------
module rsiw_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_first,
    input  logic           i_warmup,
    input  logic           i_out_ready,
    input  rsiw_pkg::t_sts i_sts,
    output logic           o_in_ready,
    output logic           o_out_valid,
    output rsiw_pkg::t_cmd o_cmd
);

    rsiw_pkg::t_state             r_state;
    rsiw_pkg::t_state             n_state;
    logic [rsiw_pkg::CNT_W-1:0]   r_cnt;
    logic [rsiw_pkg::CNT_W-1:0]   n_cnt;
    logic                         r_warm;
    logic                         n_warm;
    logic                         r_out_valid;
    logic                         n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_warm      = r_warm;
        n_out_valid = r_out_valid & ~i_out_ready;
        o_cmd       = '0;
        unique case (r_state)
            rsiw_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load  = 1'b1;
                    o_cmd.first = i_first;
                    n_warm      = i_warmup;
                    if (!i_first) begin
                        n_state = rsiw_pkg::S_DIV;
                        n_cnt   = '0;
                    end
                end
            end
            rsiw_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == rsiw_pkg::CNT_W'(rsiw_pkg::DIV_STEPS - 1)) begin
                    n_state = rsiw_pkg::S_UPD;
                end
            end
            rsiw_pkg::S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = r_warm ? rsiw_pkg::S_IDLE : rsiw_pkg::S_MUL;
            end
            rsiw_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                n_cnt     = '0;
                n_state   = i_sts.loss_zero ? rsiw_pkg::S_DONE : rsiw_pkg::S_RATIO;
            end
            rsiw_pkg::S_RATIO: begin
                o_cmd.ratio_step = 1'b1;
                n_cnt            = r_cnt + 1'b1;
                if (r_cnt == rsiw_pkg::CNT_W'(rsiw_pkg::RATIO_STEPS - 1)) begin
                    n_state = rsiw_pkg::S_DONE;
                end
            end
            rsiw_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = rsiw_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rsiw_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rsiw_pkg::S_IDLE;
            r_cnt       <= '0;
            r_warm      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_warm      <= n_warm;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == rsiw_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// File: sv/rsiw_datapath.sv
// ----------------------------------------------------------------------------
// RSI Wilder smoothing datapath
// Two serial divider lanes for the averages and a serial ratio divider.
// ----------------------------------------------------------------------------
module rsiw_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rsiw_pkg::t_cmd                 i_cmd,
    input  logic [rsiw_pkg::WIN_W-1:0]     i_divisor,
    input  logic [rsiw_pkg::CLOSE_W-1:0]   i_close_price,
    input  logic                           i_end_of_series,
    output rsiw_pkg::t_sts                 o_sts,
    output logic [rsiw_pkg::RSI_W-1:0]     o_rsi_value,
    output logic                           o_series_last
);

    // Lane 0 carries the average gain, lane 1 the average loss.
    logic [rsiw_pkg::PRICE_W-1:0] r_prev;
    logic [rsiw_pkg::AVG_W-1:0]   r_avg    [2];
    logic [rsiw_pkg::AVG_W-1:0]   r_dq     [2];
    logic [rsiw_pkg::WIN_W-1:0]   r_rem    [2];
    logic                         r_neg    [2];
    logic                         r_item_last;
    logic [rsiw_pkg::SUM_W-1:0]   r_part;
    logic [rsiw_pkg::SUM_W-1:0]   r_sum;
    logic [rsiw_pkg::RSI_W-1:0]   r_num_lo;
    logic [rsiw_pkg::RSI_W-1:0]   r_quot;
    logic [rsiw_pkg::RSI_W-1:0]   r_rsi;
    logic                         r_last;

    logic [rsiw_pkg::PRICE_W-1:0] price;
    logic                         rise;
    logic [rsiw_pkg::PRICE_W-1:0] delta;
    logic [rsiw_pkg::AVG_W-1:0]   x_val    [2];
    logic                         x_neg    [2];
    logic [rsiw_pkg::AVG_W-1:0]   x_mag    [2];
    logic [rsiw_pkg::WIN_W:0]     div_t    [2];
    logic                         div_ge   [2];
    logic [rsiw_pkg::WIN_W:0]     div_d    [2];
    logic [rsiw_pkg::AVG_W-1:0]   avg_new  [2];
    logic [rsiw_pkg::PROD_W-1:0]  prod;
    logic [rsiw_pkg::SUM_W:0]     rat_t;
    logic [rsiw_pkg::SUM_W:0]     rat_d;
    logic                         rat_ge;
    logic                         loss_zero;

    assign price = i_close_price[rsiw_pkg::PRICE_W-1:0];
    assign rise  = price > r_prev;
    assign delta = rise ? (price - r_prev) : (r_prev - price);

    always_comb begin
        x_val[0] = rise ? {delta, 16'b0} : '0;
        x_val[1] = rise ? '0 : {delta, 16'b0};
        for (int k = 0; k < 2; k++) begin
            x_neg[k]  = x_val[k] < r_avg[k];
            x_mag[k]  = x_neg[k] ? (r_avg[k] - x_val[k]) : (x_val[k] - r_avg[k]);
            div_t[k]  = {r_rem[k], r_dq[k][rsiw_pkg::AVG_W-1]};
            div_d[k]  = div_t[k] - {1'b0, i_divisor};
            div_ge[k] = div_t[k] >= {1'b0, i_divisor};
            // A negative step rounds its magnitude up so that the average floors.
            avg_new[k] = r_neg[k]
                         ? (r_avg[k] - r_dq[k] - rsiw_pkg::AVG_W'(r_rem[k] != '0))
                         : (r_avg[k] + r_dq[k]);
        end
    end

    assign loss_zero = (r_avg[1] == '0);
    assign prod      = (rsiw_pkg::PROD_W'(r_avg[0]) << 6)
                     + (rsiw_pkg::PROD_W'(r_avg[0]) << 5)
                     + (rsiw_pkg::PROD_W'(r_avg[0]) << 2);
    assign rat_t     = {r_part, r_num_lo[rsiw_pkg::RSI_W-1]};
    assign rat_d     = rat_t - {1'b0, r_sum};
    assign rat_ge    = rat_t >= {1'b0, r_sum};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= '0;
            r_avg[0] <= '0;
            r_avg[1] <= '0;
        end else if (i_cmd.load && i_cmd.first) begin
            r_prev   <= price;
            r_avg[0] <= '0;
            r_avg[1] <= '0;
        end else if (i_cmd.load) begin
            r_prev <= price;
        end else if (i_cmd.upd) begin
            r_avg[0] <= avg_new[0];
            r_avg[1] <= avg_new[1];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 2; k++) begin
            if (i_cmd.load) begin
                r_dq[k]  <= x_mag[k];
                r_rem[k] <= '0;
                r_neg[k] <= x_neg[k];
            end else if (i_cmd.div_step) begin
                r_dq[k]  <= {r_dq[k][rsiw_pkg::AVG_W-2:0], div_ge[k]};
                r_rem[k] <= div_ge[k] ? div_d[k][rsiw_pkg::WIN_W-1:0]
                                      : div_t[k][rsiw_pkg::WIN_W-1:0];
            end
        end
        if (i_cmd.load) begin
            r_item_last <= i_end_of_series;
        end
        if (i_cmd.mul) begin
            r_part   <= {1'b0, prod[rsiw_pkg::PROD_W-1:7]};
            r_num_lo <= {prod[6:0], 16'b0};
            r_sum    <= {1'b0, r_avg[0]} + {1'b0, r_avg[1]};
            r_quot   <= loss_zero ? ((r_avg[0] == '0) ? rsiw_pkg::RSI_HALF
                                                      : rsiw_pkg::RSI_FULL)
                                  : '0;
        end else if (i_cmd.ratio_step) begin
            r_part   <= rat_ge ? rat_d[rsiw_pkg::SUM_W-1:0] : rat_t[rsiw_pkg::SUM_W-1:0];
            r_num_lo <= {r_num_lo[rsiw_pkg::RSI_W-2:0], 1'b0};
            r_quot   <= {r_quot[rsiw_pkg::RSI_W-2:0], rat_ge};
        end
        if (i_cmd.out_load) begin
            r_rsi  <= r_quot;
            r_last <= r_item_last;
        end
    end

    assign o_sts.loss_zero = loss_zero;
    assign o_rsi_value     = r_rsi;
    assign o_series_last   = r_last;

endmodule
